### design/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
`timescale 1ns / 1ps
package wgm_pkg;

    localparam int STORE_CHARS = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_END      = 2'd1,
        KIND_BYTE_END = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  byte_value;
    } item_t;

endpackage

### design/wgm_front.sv
// Input stage: accept transactions, classify them and drop empty non-last items.
`timescale 1ns / 1ps
module wgm_front (
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          has_byte,
    input  logic [7:0]    byte_value,
    input  logic          last,
    output logic          push_valid,
    input  logic          push_ready,
    output wgm_pkg::item_t push_item
);
    import wgm_pkg::*;

    item_kind_t kind;

    always_comb
    begin
        priority if (has_byte && last)
        begin
            kind = KIND_BYTE_END;
        end
        else if (has_byte)
        begin
            kind = KIND_BYTE;
        end
        else
        begin
            kind = KIND_END;
        end
    end

    assign in_ready             = push_ready;
    assign push_valid           = in_valid && (has_byte || last);
    assign push_item.kind       = kind;
    assign push_item.byte_value = byte_value;

endmodule

### design/wgm_queue.sv
// Two-entry queue between the input stage and the matcher.
`timescale 1ns / 1ps
module wgm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  wgm_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output wgm_pkg::item_t pop_item
);
    import wgm_pkg::*;

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/wgm_back.sv
// Matcher: pattern registers, live-position tracker and output register.
`timescale 1ns / 1ps
module wgm_back #(
    parameter int PATTERN_CHARS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  wgm_pkg::item_t                  pop_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            matched
);
    import wgm_pkg::*;

    localparam int LEN_CAP = (PATTERN_CHARS < STORE_CHARS) ? PATTERN_CHARS : STORE_CHARS;
    localparam int POS_N   = LEN_CAP + 1;
    localparam int POS_W   = $clog2(POS_N);
    localparam int LEVELS  = $clog2(POS_N);

    logic [STORE_CHARS*8-1:0] pattern_reg;
    logic [LEN_W-1:0]         length_reg;
    logic [LEN_W-1:0]         eff_len;
    logic [POS_N-1:0]         live_reg;
    logic [POS_N-1:0]         live_next;
    logic                     at_start_reg;
    logic                     at_start_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     matched_reg;
    logic                     matched_next;
    logic [LEN_CAP-1:0]       lane_on;
    logic [LEN_CAP-1:0]       star_on;
    logic [LEN_CAP-1:0]       char_hit;
    logic [POS_N-1:0]         prop;
    logic [POS_N-1:0]         start_set;
    logic [POS_N-1:0]         cur_set;
    logic [POS_N-1:0]         seed_set;
    logic [POS_N-1:0]         adv_set;
    logic                     cfg_write;
    logic                     do_pop;
    logic                     is_end;
    logic                     is_byte;

    function automatic logic [POS_N-1:0] star_close(
        input logic [POS_N-1:0] seed,
        input logic [POS_N-1:0] pr
    );
        logic [POS_N-1:0] g;
        logic [POS_N-1:0] p;
        g = seed;
        p = pr;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            g = g | (p & (g << (1 << lvl)));
            p = p & (p << (1 << lvl));
        end
        return g;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign eff_len   = (length_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : length_reg;

    always_comb
    begin
        prop = '0;
        for (int i = 0; i < LEN_CAP; i++)
        begin
            lane_on[i]  = (LEN_W'(i) < eff_len);
            star_on[i]  = lane_on[i] && (pattern_reg[8*i +: 8] == STAR_CHAR);
            char_hit[i] = lane_on[i] && !star_on[i]
                          && ((pattern_reg[8*i +: 8] == ANY_CHAR)
                              || (pattern_reg[8*i +: 8] == pop_item.byte_value));
            prop[i+1]   = star_on[i];
        end
    end

    assign start_set = star_close(POS_N'(1), prop);
    assign cur_set   = at_start_reg ? start_set : live_reg;

    always_comb
    begin
        seed_set = '0;
        for (int i = 0; i < LEN_CAP; i++)
        begin
            if (cur_set[i] && star_on[i])
            begin
                seed_set[i] = 1'b1;
            end
            if (cur_set[i] && char_hit[i])
            begin
                seed_set[i+1] = 1'b1;
            end
        end
    end

    assign adv_set = star_close(seed_set, prop);

    always_comb
    begin
        is_end  = 1'b0;
        is_byte = 1'b0;
        unique case (pop_item.kind)
            KIND_BYTE:
            begin
                is_byte = 1'b1;
            end
            KIND_END:
            begin
                is_end = 1'b1;
            end
            KIND_BYTE_END:
            begin
                is_byte = 1'b1;
                is_end  = 1'b1;
            end
            default:
            begin
                is_byte = 1'b0;
                is_end  = 1'b0;
            end
        endcase
    end

    assign pop_ready = !is_end || !out_valid_reg || out_ready;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        live_next      = live_reg;
        at_start_next  = at_start_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        if (cfg_write)
        begin
            at_start_next = 1'b1;
        end
        else if (do_pop)
        begin
            if (is_end)
            begin
                out_valid_next = 1'b1;
                matched_next   = is_byte ? adv_set[eff_len[POS_W-1:0]]
                                         : cur_set[eff_len[POS_W-1:0]];
                at_start_next  = 1'b1;
            end
            else
            begin
                live_next     = adv_set;
                at_start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            length_reg    <= '0;
            live_reg      <= '0;
            at_start_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            at_start_reg  <= at_start_next;
            out_valid_reg <= out_valid_next;
            matched_reg   <= matched_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PATTERN_WORD_0: pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_WORD_1: pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_WORD_2: pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_WORD_3: pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                        length_reg <= length_reg;
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

### design/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher.
`timescale 1ns / 1ps
// Streams a byte string, one byte per input transaction, against a wildcard
// pattern ('*' any run, '?' any one byte) held in configuration registers.
// Input channel: in_valid/in_ready with has_byte, byte_value and last; last
// closes the string, has_byte = 0 with last = 1 closes it without a byte.
// Output channel: out_valid/out_ready with matched, one transaction per string.
// Configuration channel: cfg_valid/cfg_ready, cfg_index selects pattern word
// 0..3 or the pattern length; every write restarts the tracker. Write only
// while no string is in flight.
// Throughput: one input transaction per cycle, unless a stalled receiver backs
// up the queue. The live-position update is a per-position compare plus a
// log-depth star closure, computed combinationally for each byte.
// After the last transaction is taken, its item is written into the queue, then
// the result into the output register.
// Reset: pattern and length clear, the tracker sits at its start set, no
// result is pending. A stalled receiver fills the output register and then
// the two-entry queue, after which in_ready drops; byte-only transactions
// keep draining while a result waits.
module wildcard_glob_matcher_top #(
    parameter int PATTERN_CHARS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            has_byte,
    input  logic [7:0]                      byte_value,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            matched
);
    import wgm_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    wgm_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .has_byte   (has_byte),
        .byte_value (byte_value),
        .last       (last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    wgm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    wgm_back #(
        .PATTERN_CHARS (PATTERN_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched)
    );

endmodule

### sim/wildcard_glob_matcher_checker.sv
// Checker for the wildcard glob matcher: tracks live pattern positions and scores each result.
`timescale 1ns / 1ps
module wildcard_glob_matcher_checker #(
    parameter int PATTERN_CHARS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            has_byte,
    input  logic [7:0]                      byte_value,
    input  logic                            last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            matched,
    output int                              fail_count,
    output int                              pending_results
);
    import wgm_pkg::*;

    localparam int LEN_CAP      = (PATTERN_CHARS < STORE_CHARS) ? PATTERN_CHARS : STORE_CHARS;
    localparam int REPORT_LIMIT = 40;
    localparam logic [STORE_CHARS:0] START_POS = {{STORE_CHARS{1'b0}}, 1'b1};

    logic [7:0]         pattern_mem [STORE_CHARS];
    logic [LEN_W-1:0]   length_reg;
    logic [STORE_CHARS:0] live_pos;
    logic               match_q [$];
    int                 errors = 0;

    assign fail_count = errors;

    function automatic int active_len();
        int n;
        n = int'(length_reg);
        return (n > LEN_CAP) ? LEN_CAP : n;
    endfunction

    function automatic logic [STORE_CHARS:0] close_stars(input logic [STORE_CHARS:0] pos);
        int n;
        int i;
        n = active_len();
        for (i = 0; i < n; i++)
        begin
            if (pos[i] && pattern_mem[i] == STAR_CHAR)
                pos[i+1] = 1'b1;
        end
        return pos;
    endfunction

    function automatic logic [STORE_CHARS:0] consume_byte(input logic [STORE_CHARS:0] pos,
                                                         input logic [7:0] b);
        logic [STORE_CHARS:0] nxt;
        int n;
        int i;
        nxt = '0;
        n = active_len();
        for (i = 0; i < n; i++)
        begin
            if (pos[i])
            begin
                if (pattern_mem[i] == STAR_CHAR)
                    nxt[i] = 1'b1;
                else if (pattern_mem[i] == ANY_CHAR || pattern_mem[i] == b)
                    nxt[i+1] = 1'b1;
            end
        end
        return close_stars(nxt);
    endfunction

    task automatic report(input string msg);
        if (errors < REPORT_LIMIT)
            $display("ERROR %0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        int w;
        int j;
        if (!rst_n)
        begin
            for (j = 0; j < STORE_CHARS; j++)
                pattern_mem[j] = 8'h00;
            length_reg = '0;
            live_pos = close_stars(START_POS);
            match_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_WORD_0, REG_PATTERN_WORD_1,
                    REG_PATTERN_WORD_2, REG_PATTERN_WORD_3:
                    begin
                        w = int'(cfg_index);
                        for (j = 0; j < 8; j++)
                            pattern_mem[8*w+j] = cfg_data[8*j +: 8];
                    end
                    REG_PATTERN_LENGTH: length_reg = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
                live_pos = close_stars(START_POS);
            end
            if (in_valid && in_ready)
            begin
                if (has_byte)
                    live_pos = consume_byte(live_pos, byte_value);
                if (last)
                begin
                    match_q = {match_q, live_pos[active_len()]};
                    live_pos = close_stars(START_POS);
                end
            end
            if (out_valid && out_ready)
            begin
                if (match_q.size() == 0)
                    report($sformatf("result with none expected, matched %0b", matched));
                else
                begin
                    want = match_q.pop_front();
                    if (matched !== want)
                        report($sformatf("matched %0b, expected %0b", matched, want));
                end
            end
            pending_results <= match_q.size();
        end
    end

endmodule

### sim/wildcard_glob_matcher_top_tb.sv
// Testbench top for the wildcard glob matcher: drives strings and patterns, gives the verdict.
`timescale 1ns / 1ps
module wildcard_glob_matcher_top_tb;
    import wgm_pkg::*;

    localparam int PATTERN_CHARS = 32;
    localparam int LEN_CAP       = (PATTERN_CHARS < STORE_CHARS) ? PATTERN_CHARS : STORE_CHARS;
    localparam int ITEM_TARGET   = 1550;
    localparam int PHASE_ITEMS   = 120;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_PATTERN_LENGTH + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   has_byte;
    logic [7:0]             byte_value;
    logic                   last;
    logic                   out_valid;
    logic                   out_ready;
    logic                   matched;
    int                     fail_count;
    int                     pending_results;

    bit                     calm;
    int                     items_done;
    int                     eff_len;
    logic [7:0]             pat_bytes [STORE_CHARS];
    logic [CFG_DATA_W-1:0]  length_data;
    logic [7:0]             text_q [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    wildcard_glob_matcher_top #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .has_byte   (has_byte),
        .byte_value (byte_value),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .matched    (matched)
    );

    wildcard_glob_matcher_checker #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .has_byte        (has_byte),
        .byte_value      (byte_value),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .matched         (matched),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    function automatic logic [7:0] pick_pattern_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return STAR_CHAR;
            3, 4:    return ANY_CHAR;
            5:       return "a";
            6:       return "b";
            7:       return 8'h00;
            8:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 8))
            0, 1:    return "a";
            2:       return "b";
            3:       return 8'h00;
            4:       return 8'hFF;
            5:       return STAR_CHAR;
            6:       return ANY_CHAR;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input bit hb, input logic [7:0] bv, input bit lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        has_byte   <= hb;
        byte_value <= bv;
        last       <= lst;
        do @(posedge clk); while (!in_ready);
        items_done++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_pattern();
        logic [CFG_INDEX_W-1:0] order [5];
        logic [CFG_INDEX_W-1:0] tmp;
        logic [CFG_DATA_W-1:0]  word;
        int j;
        int k;
        order = '{REG_PATTERN_WORD_0, REG_PATTERN_WORD_1, REG_PATTERN_WORD_2,
                  REG_PATTERN_WORD_3, REG_PATTERN_LENGTH};
        for (k = 4; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      {$urandom, $urandom});
        for (k = 0; k < 5; k++)
        begin
            if (order[k] == REG_PATTERN_LENGTH)
                word = length_data;
            else
                for (j = 0; j < 8; j++)
                    word[8*j +: 8] = pat_bytes[8*int'(order[k]) + j];
            cfg_write(order[k], word);
        end
        cfg_valid <= 1'b0;
        eff_len = (int'(length_data[LEN_W-1:0]) > LEN_CAP) ? LEN_CAP
                                                         : int'(length_data[LEN_W-1:0]);
    endtask

    task automatic build_text();
        int mode;
        int i;
        int n;
        int pos;
        text_q.delete();
        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            for (i = 0; i < eff_len; i++)
            begin
                if (pat_bytes[i] == STAR_CHAR)
                begin
                    n = $urandom_range(0, 3);
                    repeat (n) text_q = {text_q, pick_text_byte()};
                end
                else if (pat_bytes[i] == ANY_CHAR)
                    text_q = {text_q, 8'($urandom)};
                else
                    text_q = {text_q, pat_bytes[i]};
            end
            if (mode >= 5)
            begin
                pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
                case ($urandom_range(0, 2))
                    0: if (text_q.size() != 0) text_q[pos] = pick_text_byte();
                    1: if (text_q.size() != 0) text_q.delete(pos);
                    default: text_q.insert(pos, pick_text_byte());
                endcase
            end
        end
        else
        begin
            n = $urandom_range(0, 6);
            repeat (n) text_q = {text_q, pick_text_byte()};
        end
    endtask

    task automatic send_text();
        bit sep_end;
        int i;
        sep_end = (text_q.size() == 0) || ($urandom_range(0, 3) == 0);
        for (i = 0; i < text_q.size(); i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'b0, 8'($urandom), 1'b0);
            send_item(1'b1, text_q[i], !sep_end && (i == text_q.size() - 1));
        end
        if (sep_end)
            send_item(1'b0, 8'($urandom), 1'b1);
    endtask

    initial
    begin
        #(10_000_000);
        $display("FAIL wildcard_glob_matcher_top");
        $finish;
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        int phase;
        int phase_start;
        int i;
        int len;
        int r;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        has_byte   = 1'b0;
        byte_value = 8'h00;
        last       = 1'b0;
        calm       = 1'b0;
        items_done = 0;
        eff_len    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset: empty string, stray marker, dead tracker
        send_item(1'b0, 8'h00, 1'b1);
        send_item(1'b0, 8'hFF, 1'b0);
        send_item(1'b1, 8'h00, 1'b1);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b0, 8'h5A, 1'b1);
        drain();

        for (i = 0; i < STORE_CHARS; i++)
            pat_bytes[i] = 8'($urandom);
        pat_bytes[0] = STAR_CHAR;
        pat_bytes[1] = STAR_CHAR;
        pat_bytes[2] = "a";
        pat_bytes[3] = ANY_CHAR;
        pat_bytes[4] = 8'h00;
        pat_bytes[5] = 8'hFF;
        pat_bytes[6] = STAR_CHAR;
        length_data = {$urandom, $urandom};
        length_data[LEN_W-1:0] = LEN_W'(7);
        load_pattern();
        send_item(1'b1, "a", 1'b0);
        send_item(1'b1, 8'h55, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b0, 8'h00, 1'b1);
        send_item(1'b1, "q", 1'b0);
        send_item(1'b1, "a", 1'b0);
        send_item(1'b1, ANY_CHAR, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, "z", 1'b1);
        send_item(1'b1, "a", 1'b0);
        send_item(1'b1, 8'h00, 1'b1);
        send_item(1'b0, 8'h00, 1'b1);
        drain();

        items_done = 0;
        phase = 0;
        while (items_done < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 0)
            begin
                for (i = 0; i < STORE_CHARS; i++)
                    pat_bytes[i] = 8'hFF;
                length_data = '1;
            end
            else if (phase == 1)
            begin
                for (i = 0; i < STORE_CHARS; i++)
                    pat_bytes[i] = 8'h00;
                length_data = '0;
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    len = $urandom_range(0, 8);
                else if (r < 8)
                    len = $urandom_range(9, 31);
                else if (r == 8)
                    len = STORE_CHARS;
                else
                    len = $urandom_range(STORE_CHARS + 1, (1 << LEN_W) - 1);
                for (i = 0; i < STORE_CHARS; i++)
                    pat_bytes[i] = (i < len) ? pick_pattern_char() : 8'($urandom);
                length_data = {$urandom, $urandom};
                length_data[LEN_W-1:0] = LEN_W'(len);
            end
            load_pattern();
            phase_start = items_done;
            while (items_done - phase_start < PHASE_ITEMS && items_done < ITEM_TARGET)
            begin
                build_text();
                send_text();
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            drain();
            phase++;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS wildcard_glob_matcher_top");
        else
            $display("FAIL wildcard_glob_matcher_top");
        $finish;
    end

endmodule
